/* rtl/tkpd_pkg.sv */
// ----------------------------------------------------------------------------
// tkpd_pkg
// Shared widths, register codes, event type and key mapping for the touch
// key press detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tkpd_pkg;

	localparam int CountBits   = 14;
	localparam int NumGroups   = 3;
	localparam int NumPhases   = 3;
	localparam int NumChannels = NumGroups * NumPhases;
	localparam int ChBits      = $clog2(NumChannels);
	localparam int KeyBits     = 3;
	localparam int CfgIdxBits  = 2;
	localparam int CfgDataBits = CountBits;

	typedef logic [CountBits-1:0] count_t;
	typedef logic [1:0]           phase_t;
	typedef logic [1:0]           group_t;

	// configuration register indexes
	localparam logic [CfgIdxBits-1:0] CFG_THRESHOLD  = 2'd0;
	localparam logic [CfgIdxBits-1:0] CFG_BASELINE   = 2'd1;
	localparam logic [CfgIdxBits-1:0] CFG_SATURATION = 2'd2;
	localparam logic [CfgIdxBits-1:0] CFG_ENABLE     = 2'd3;

	localparam count_t                 ThresholdReset  = 14'd1000;
	localparam count_t                 BaselineReset   = 14'd2000;
	localparam count_t                 SaturationReset = 14'd16383;
	localparam logic [NumChannels-1:0] EnableReset     = 9'd255;

	typedef struct packed {
		logic [KeyBits-1:0] key_index;
		logic               key_down;
		count_t             key_count;
	} evt_t;

	// events produced by one acquisition, slot g belongs to group g
	typedef struct packed {
		logic [NumGroups-1:0] hit;
		evt_t [NumGroups-1:0] evt;
	} evt_set_t;

	// left, right, center groups against the scan phase
	function automatic logic [KeyBits-1:0] key_map(input group_t grp, input phase_t ph);
		logic [KeyBits-1:0] k;
		k = 3'd0;
		case ({grp, ph})
			4'b00_00: k = 3'd2;
			4'b00_01: k = 3'd1;
			4'b00_10: k = 3'd0;
			4'b01_00: k = 3'd5;
			4'b01_01: k = 3'd4;
			4'b01_10: k = 3'd3;
			4'b10_00: k = 3'd6;
			4'b10_01: k = 3'd7;
			4'b10_10: k = 3'd0;
			default:  k = 3'd0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

/* rtl/tkpd_chan.sv */
// ----------------------------------------------------------------------------
// tkpd_chan
// Threshold decision for one channel: absolute difference from the baseline
// against the press threshold, with enable and saturation masking.
// ----------------------------------------------------------------------------
`default_nettype none

module tkpd_chan (
	input  wire tkpd_pkg::count_t count,
	input  wire tkpd_pkg::count_t threshold,
	input  wire tkpd_pkg::count_t baseline,
	input  wire tkpd_pkg::count_t saturation,
	input  wire                   enable,
	input  wire                   pressed_old,
	output logic                  hit,
	output logic                  pressed_new
);

	tkpd_pkg::count_t diff;
	logic             now;

	always_comb begin
		if (count >= baseline) begin
			diff = count - baseline;
		end else begin
			diff = baseline - count;
		end
		now         = (diff > threshold);
		hit         = enable && (count != saturation) && (now != pressed_old);
		pressed_new = hit ? now : pressed_old;
	end

endmodule

`default_nettype wire

/* rtl/tkpd_evq.sv */
// ----------------------------------------------------------------------------
// tkpd_evq
// Event buffer: holds the events of one acquisition and hands them out one
// word per cycle unless stalled, in group order, marking the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module tkpd_evq (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       load,
	input  wire tkpd_pkg::evt_set_t   set_in,
	output logic                      busy,
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic [tkpd_pkg::KeyBits-1:0] key_index,
	output logic                      key_down,
	output tkpd_pkg::count_t          key_count,
	output logic                      last_event
);

	logic [tkpd_pkg::NumGroups-1:0] pend_q;
	tkpd_pkg::evt_t [tkpd_pkg::NumGroups-1:0] evt_q;
	logic [tkpd_pkg::NumGroups-1:0] sel;
	logic [tkpd_pkg::NumGroups-1:0] below;
	tkpd_pkg::evt_t cur;

	// pick the lowest pending slot
	always_comb begin
		below = '0;
		sel   = '0;
		cur   = '0;
		for (int g = 0; g < tkpd_pkg::NumGroups; g++) begin
			sel[g] = pend_q[g] && (below == '0);
			if (sel[g]) begin
				cur = evt_q[g];
			end
			below[g] = pend_q[g];
		end
	end

	assign busy       = (pend_q != '0);
	assign out_valid  = busy;
	assign key_index  = cur.key_index;
	assign key_down   = cur.key_down;
	assign key_count  = cur.key_count;
	assign last_event = ((pend_q & ~sel) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= set_in.hit;
		end else if (out_valid && !out_stall) begin
			pend_q <= pend_q & ~sel;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			evt_q <= set_in.evt;
		end
	end

endmodule

`default_nettype wire

/* rtl/touch_key_press_detector_top.sv */
// ----------------------------------------------------------------------------
// touch_key_press_detector_top
// Touch key press detector: per acquisition, compares the three group
// counts of the current scan phase with baseline and threshold and emits
// one event word per key state change.
//
//   channel  signals                                  direction
//   in       in_valid/in_stall, count_group_a..c      acquisition in
//   out      out_valid/out_stall, key_index, key_down,
//            key_count, last_event                    events out
//   cfg      cfg_we, cfg_index, cfg_data              register writes
//
// An acquisition is registered, then evaluated combinationally into the
// event buffer, from which its event words leave. Acquisitions with no
// events pass at one per cycle while the buffer is empty. One with events
// holds the next one in the input register: the buffer sends one word per
// cycle on the single output port unless stalled, reloading only once empty.
// Reset clears the phase, key states and registers to their defaults; a
// stalled output holds the buffer and, through it, the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_key_press_detector_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire tkpd_pkg::count_t            count_group_a,
	input  wire tkpd_pkg::count_t            count_group_b,
	input  wire tkpd_pkg::count_t            count_group_c,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [tkpd_pkg::KeyBits-1:0]     key_index,
	output logic                             key_down,
	output tkpd_pkg::count_t                 key_count,
	output logic                             last_event,
	input  wire                              cfg_we,
	input  wire [tkpd_pkg::CfgIdxBits-1:0]   cfg_index,
	input  wire [tkpd_pkg::CfgDataBits-1:0]  cfg_data
);

	tkpd_pkg::count_t                    threshold_q;
	tkpd_pkg::count_t                    baseline_q;
	tkpd_pkg::count_t                    saturation_q;
	logic [tkpd_pkg::NumChannels-1:0]    enable_q;

	logic                                valid_s1;
	tkpd_pkg::count_t [tkpd_pkg::NumGroups-1:0] count_s1;
	tkpd_pkg::phase_t                    phase_q;
	tkpd_pkg::phase_t                    phase;
	logic [tkpd_pkg::NumChannels-1:0]    pressed_q;
	logic [tkpd_pkg::NumChannels-1:0]    pressed_d;

	logic                                busy;
	logic                                in_acc;
	logic                                adv;
	tkpd_pkg::evt_set_t                  set;

	logic [tkpd_pkg::NumGroups-1:0]      hit;
	logic [tkpd_pkg::NumGroups-1:0]      pnew;
	logic [tkpd_pkg::NumGroups-1:0]      pold;
	logic [tkpd_pkg::NumGroups-1:0]      en;
	logic [tkpd_pkg::ChBits-1:0]         ch [tkpd_pkg::NumGroups];

	assign in_stall = valid_s1 && busy;
	assign in_acc   = in_valid && !in_stall;
	assign adv      = valid_s1 && !busy;
	// phase three never occurs; fold it onto phase zero
	assign phase    = (phase_q == 2'd3) ? 2'd0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= tkpd_pkg::ThresholdReset;
			baseline_q   <= tkpd_pkg::BaselineReset;
			saturation_q <= tkpd_pkg::SaturationReset;
			enable_q     <= tkpd_pkg::EnableReset;
		end else if (cfg_we) begin
			case (cfg_index)
				tkpd_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_data;
				tkpd_pkg::CFG_BASELINE:   baseline_q   <= cfg_data;
				tkpd_pkg::CFG_SATURATION: saturation_q <= cfg_data;
				tkpd_pkg::CFG_ENABLE:     enable_q     <= cfg_data[tkpd_pkg::NumChannels-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			count_s1[0] <= count_group_a;
			count_s1[1] <= count_group_b;
			count_s1[2] <= count_group_c;
		end
	end

	genvar g;
	generate
		for (g = 0; g < tkpd_pkg::NumGroups; g++) begin : g_chan
			assign ch[g] = tkpd_pkg::ChBits'(g * tkpd_pkg::NumPhases) +
				tkpd_pkg::ChBits'(phase);
			assign en[g]   = enable_q[ch[g]];
			assign pold[g] = pressed_q[ch[g]];

			tkpd_chan u_chan (
				.count       (count_s1[g]),
				.threshold   (threshold_q),
				.baseline    (baseline_q),
				.saturation  (saturation_q),
				.enable      (en[g]),
				.pressed_old (pold[g]),
				.hit         (hit[g]),
				.pressed_new (pnew[g])
			);

			assign set.hit[g]           = hit[g];
			assign set.evt[g].key_index = tkpd_pkg::key_map(tkpd_pkg::group_t'(g), phase);
			assign set.evt[g].key_down  = pnew[g];
			assign set.evt[g].key_count = count_s1[g];
		end
	endgenerate

	always_comb begin
		pressed_d = pressed_q;
		for (int i = 0; i < tkpd_pkg::NumGroups; i++) begin
			pressed_d[ch[i]] = pnew[i];
		end
	end

	// advance phase and key states as the acquisition leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			pressed_q <= '0;
		end else if (adv) begin
			phase_q   <= (phase == 2'(tkpd_pkg::NumPhases - 1)) ? 2'd0 : phase + 2'd1;
			pressed_q <= pressed_d;
		end
	end

	tkpd_evq u_evq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv),
		.set_in     (set),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_index  (key_index),
		.key_down   (key_down),
		.key_count  (key_count),
		.last_event (last_event)
	);

endmodule

`default_nettype wire
